### rtl/mcsg_pkg.sv
package mcsg_pkg;

  localparam int unsigned RADIUS_W     = 6;
  localparam int unsigned COLOR_W      = 16;
  localparam int unsigned COORD_W      = 16;
  localparam int unsigned STEP_X_W     = 7;
  localparam int unsigned STEP_Y_W     = 7;
  localparam int unsigned DEC_W        = 12;
  localparam int unsigned RESULT_LIMIT = 48;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_CIRCLE_RADIUS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_COLOR    = 1'b1;

  typedef struct packed {
    logic [7:0] center_x;
    logic [7:0] center_y;
  } mcsg_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] narrow_x_start;
    logic [COORD_W-1:0] narrow_x_end;
    logic [COORD_W-1:0] narrow_row_low;
    logic [COORD_W-1:0] narrow_row_high;
    logic [COORD_W-1:0] wide_x_start;
    logic [COORD_W-1:0] wide_x_end;
    logic [COORD_W-1:0] wide_row_low;
    logic [COORD_W-1:0] wide_row_high;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_span_set;
  } mcsg_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mcsg_state_t;

  typedef struct packed {
    logic start;
    logic emit;
  } mcsg_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } mcsg_status_t;

endpackage

### rtl/mcsg_ctrl.sv
module mcsg_ctrl
  import mcsg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  mcsg_status_t status,
  output mcsg_cmd_t    cmd
);

  mcsg_state_t state;
  mcsg_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.emit = status.out_free;
        // last result handed to the output register ends the circle
        if (status.out_free && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/mcsg_datapath.sv
module mcsg_datapath
  import mcsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  mcsg_cmd_t           cmd,
  output mcsg_status_t        status,
  input  mcsg_in_t            in_data,
  input  logic [RADIUS_W-1:0] radius,
  input  logic [COLOR_W-1:0]  color,
  output logic                out_valid,
  input  logic                out_stall,
  output mcsg_out_t           out_data
);

  logic [7:0]                 cx;
  logic [7:0]                 cy;
  logic [STEP_X_W-1:0]        x;
  logic signed [STEP_Y_W-1:0] y;
  logic [DEC_W-1:0]           d;
  logic [COUNT_W-1:0]         k;

  logic [STEP_X_W-1:0]        x_next;
  logic signed [STEP_Y_W-1:0] y_next;
  logic [DEC_W-1:0]           d_next;
  logic [DEC_W-1:0]           xe;
  logic [DEC_W-1:0]           ye;
  logic                       d_pos;
  logic                       last_now;
  logic [COORD_W-1:0]         cx16;
  logic [COORD_W-1:0]         cy16;
  logic [COORD_W-1:0]         x16;
  logic [COORD_W-1:0]         y16;
  mcsg_out_t                  result;

  assign d_pos  = !d[DEC_W-1] && (d != '0);
  assign x_next = x + STEP_X_W'(1);
  assign y_next = d_pos ? (y - STEP_Y_W'(1)) : y;
  assign xe     = {{(DEC_W-STEP_X_W){1'b0}}, x_next};
  assign ye     = {{(DEC_W-STEP_Y_W){y_next[STEP_Y_W-1]}}, y_next};

  always_comb begin
    if (d_pos) begin
      d_next = d + ((xe - ye) << 2) + DEC_W'(10);
    end else begin
      d_next = d + (xe << 2) + DEC_W'(6);
    end
  end

  // y has dropped below x, or the result budget is used up
  assign last_now = ($signed(y) < $signed({1'b0, x})) ||
                    (k == COUNT_W'(RESULT_LIMIT - 1));

  assign cx16 = {{(COORD_W-8){1'b0}}, cx};
  assign cy16 = {{(COORD_W-8){1'b0}}, cy};
  assign x16  = {{(COORD_W-STEP_X_W){1'b0}}, x};
  assign y16  = {{(COORD_W-STEP_Y_W){y[STEP_Y_W-1]}}, y};

  always_comb begin
    result.narrow_x_start  = cx16 - x16;
    result.narrow_x_end    = cx16 + x16;
    result.narrow_row_low  = cy16 + y16;
    result.narrow_row_high = cy16 - y16;
    result.wide_x_start    = cx16 - y16;
    result.wide_x_end      = cx16 + y16;
    result.wide_row_low    = cy16 + x16;
    result.wide_row_high   = cy16 - x16;
    result.pixel_color     = color;
    result.last_span_set   = last_now;
  end

  assign status.last     = last_now;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx <= in_data.center_x;
      cy <= in_data.center_y;
      x  <= '0;
      y  <= signed'({1'b0, radius});
      d  <= DEC_W'(3) - {{(DEC_W-RADIUS_W-1){1'b0}}, radius, 1'b0};
      k  <= '0;
    end else if (cmd.emit) begin
      x <= x_next;
      y <= y_next;
      d <= d_next;
      k <= k + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= result;
    end
  end

endmodule

### rtl/midpoint_circle_span_generator_unit.sv
// Filled-circle span generator.
// An input item on in_data (center_x, center_y) starts one circle of the
// configured radius and colour; the block answers with one result item per
// midpoint decision step on out_data, each holding a narrow and a wide pair
// of horizontal spans, the final one marked by last_span_set.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 = circle_radius and
// 1 = fill_color; cfg_ready is always high. A radius above MAX_RADIUS is
// clamped to MAX_RADIUS.
// Timing: on acceptance the step registers are set up from the item; the
// first result is then loaded into the output register as soon as it is free,
// then one result per cycle while out_stall is low. A circle of radius r
// gives about 0.71*r + 2 results, at most 48. The step registers (x, y,
// decision value) advance once per loaded result, so a new item cannot be
// taken until the circle's last result has been loaded.
// in_stall is high from acceptance until the last result has been loaded into
// the output register; the next item may be accepted while that last result
// still waits there. out_stall freezes a valid output register and the stepping.
// Reset (rst, synchronous) empties the output register, drops any circle in
// progress and sets radius 10 and colour 0.
module midpoint_circle_span_generator_unit
  import mcsg_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 63
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mcsg_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mcsg_out_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]     cfg_data
);

  logic [RADIUS_W-1:0] circle_radius;
  logic [COLOR_W-1:0]  fill_color;
  logic [RADIUS_W-1:0] radius_sat;
  mcsg_cmd_t           cmd;
  mcsg_status_t        status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= RADIUS_W'(10);
      fill_color    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CIRCLE_RADIUS: circle_radius <= cfg_data[RADIUS_W-1:0];
        CFG_FILL_COLOR:    fill_color    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign radius_sat = (circle_radius > RADIUS_W'(MAX_RADIUS)) ?
                      RADIUS_W'(MAX_RADIUS) : circle_radius;

  mcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mcsg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .radius    (radius_sat),
    .color     (fill_color),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/mcsg_checker.sv
module mcsg_checker
  import mcsg_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input mcsg_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input mcsg_out_t out_data
);

  // a stalled result item holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // a waiting input item holds
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed");

  // one circle at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a circle is in progress");

  // the block frees up only once the last result is out
  assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) && !$past(rst) |-> out_valid && out_data.last_span_set)
    else $error("circle ended without a last result");

endmodule

bind midpoint_circle_span_generator_unit mcsg_checker u_mcsg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
